FILE: rtl/bpq_pkg.sv
// Package for the BMP pixel palette quantizer.
// Holds sizes, register indexes, the six-color palette and small helper functions.
// No dependencies.
package bpq_pkg;

    localparam int unsigned MAX_WIDTH_DEFAULT  = 4096;
    localparam int unsigned MAX_HEIGHT_DEFAULT = 4096;

    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned CFG_DATA_W  = 13;
    localparam int unsigned CFG_INDEX_W = 4;
    localparam int unsigned INDEX_W     = 24;
    localparam int unsigned CODE_W      = 3;

    localparam int unsigned QUEUE_DEPTH = 2;

    localparam int unsigned SQ_W      = 2 * BYTE_W;
    localparam int unsigned SUM_W     = SQ_W + 2;
    localparam int unsigned RAD_W     = SUM_W + 1;
    localparam int unsigned ROOT_W    = 10;
    localparam logic [RAD_W-1:0] ROOT_BIT0 = RAD_W'(1) << (SUM_W - 2);

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_IMAGE_WIDTH  = 0,
        REG_IMAGE_HEIGHT = 1
    } cfg_reg_t;

    typedef struct packed {
        logic [BYTE_W-1:0] red;
        logic [BYTE_W-1:0] green;
        logic [BYTE_W-1:0] blue;
    } rgb_t;

    localparam int unsigned PALETTE_SIZE = 6;

    localparam rgb_t PALETTE [PALETTE_SIZE] = '{
        '{8'd255, 8'd0,   8'd0},
        '{8'd255, 8'd165, 8'd0},
        '{8'd255, 8'd255, 8'd0},
        '{8'd0,   8'd255, 8'd0},
        '{8'd0,   8'd0,   8'd255},
        '{8'd255, 8'd255, 8'd255}
    };

    function automatic logic [31:0] eff_dim(input logic [CFG_DATA_W-1:0] v,
                                             input int unsigned maxv);
        logic [31:0] r;
        if (v == '0)
        begin
            r = 32'd1;
        end
        else if (32'(v) > maxv)
        begin
            r = maxv;
        end
        else
        begin
            r = 32'(v);
        end
        return r;
    endfunction

    function automatic logic [BYTE_W-1:0] abs_diff(input logic [BYTE_W-1:0] a,
                                                   input logic [BYTE_W-1:0] b);
        logic [BYTE_W-1:0] r;
        if (a > b)
        begin
            r = a - b;
        end
        else
        begin
            r = b - a;
        end
        return r;
    endfunction

endpackage

FILE: rtl/bpq_if.sv
// Channel interfaces of the BMP pixel palette quantizer.
// Byte input, pixel result output and configuration write channels.
// Depends on bpq_pkg.
interface bpq_byte_if;
    logic                        valid;
    logic                        ready;
    logic [bpq_pkg::BYTE_W-1:0]  data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink (input valid, input data_byte, output ready);
endinterface

interface bpq_pixel_if;
    logic                        valid;
    logic                        ready;
    logic [bpq_pkg::INDEX_W-1:0] pixel_index;
    logic [bpq_pkg::CODE_W-1:0]  color_code;
    logic                        last_pixel;

    modport source (output valid, output pixel_index, output color_code,
                    output last_pixel, input ready);
    modport sink (input valid, input pixel_index, input color_code,
                  input last_pixel, output ready);
endinterface

interface bpq_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [bpq_pkg::CFG_INDEX_W-1:0] index;
    logic [bpq_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

FILE: rtl/bpq_front.sv
// Front end: takes raw pixel-data bytes, drops row padding and gathers pixels.
// Tracks row, column and byte phase, and pushes one job per complete pixel.
// Depends on bpq_pkg and bpq_if.
module bpq_front #(
    parameter int unsigned MAX_WIDTH  = bpq_pkg::MAX_WIDTH_DEFAULT,
    parameter int unsigned MAX_HEIGHT = bpq_pkg::MAX_HEIGHT_DEFAULT,
    localparam int unsigned WW    = $clog2(MAX_WIDTH + 1),
    localparam int unsigned HW    = $clog2(MAX_HEIGHT + 1),
    localparam int unsigned JOB_W = 3 * bpq_pkg::BYTE_W + HW + WW + 1
) (
    input  logic             clk,
    input  logic             rst_n,
    bpq_byte_if.sink         byte_in,
    bpq_cfg_if.sink          cfg,
    output logic             push,
    output logic [JOB_W-1:0] job,
    input  logic             full,
    output logic [WW-1:0]    width_eff
);
    import bpq_pkg::*;

    localparam int unsigned DB_W = WW + 2;
    localparam int unsigned RB_W = WW + 3;

    typedef enum logic [1:0] {
        PH_BLUE,
        PH_GREEN,
        PH_RED
    } phase_t;

    logic [WW-1:0]     w_eff_reg;
    logic [HW-1:0]     h_eff_reg;
    logic [RB_W-1:0]   rbp_reg;
    logic [HW-1:0]     file_row_reg;
    logic [WW-1:0]     col_reg;
    phase_t            byte_phase_reg;
    logic [BYTE_W-1:0] held_blue_reg;
    logic [BYTE_W-1:0] held_green_reg;

    logic [DB_W-1:0]   data_bytes;
    logic [RB_W-1:0]   padded;
    logic [RB_W-1:0]   rbp_inc;
    logic [HW-1:0]     frow;
    logic [HW-1:0]     frow_inc;
    logic [HW-1:0]     trow;
    logic              in_data;
    logic              needs_push;
    logic              is_last;
    logic              accept;
    logic              cfg_write;

    assign data_bytes = ({2'b00, w_eff_reg} << 1) + {2'b00, w_eff_reg};
    assign padded     = ({1'b0, data_bytes} + RB_W'(3)) & ~RB_W'(3);
    assign rbp_inc    = rbp_reg + RB_W'(1);
    assign in_data    = rbp_reg < {1'b0, data_bytes};
    assign needs_push = in_data && (byte_phase_reg == PH_RED);

    assign frow     = (file_row_reg < h_eff_reg) ? file_row_reg : h_eff_reg - HW'(1);
    assign frow_inc = file_row_reg + HW'(1);
    assign trow     = h_eff_reg - HW'(1) - frow;
    assign is_last  = (frow == h_eff_reg - HW'(1)) && (col_reg == w_eff_reg - WW'(1));

    assign cfg.ready     = 1'b1;
    assign cfg_write     = cfg.valid && cfg.ready;
    assign byte_in.ready = !cfg.valid && (!needs_push || !full);
    assign accept        = byte_in.valid && byte_in.ready;

    assign push      = accept && needs_push;
    assign job       = {byte_in.data_byte, held_green_reg, held_blue_reg, trow, col_reg, is_last};
    assign width_eff = w_eff_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_eff_reg      <= WW'(1);
            h_eff_reg      <= HW'(1);
            rbp_reg        <= '0;
            file_row_reg   <= '0;
            col_reg        <= '0;
            byte_phase_reg <= PH_BLUE;
            held_blue_reg  <= '0;
            held_green_reg <= '0;
        end
        else if (cfg_write)
        begin
            if (cfg.index == REG_IMAGE_WIDTH || cfg.index == REG_IMAGE_HEIGHT)
            begin
                rbp_reg        <= '0;
                file_row_reg   <= '0;
                col_reg        <= '0;
                byte_phase_reg <= PH_BLUE;
            end
            if (cfg.index == REG_IMAGE_WIDTH)
            begin
                w_eff_reg <= WW'(eff_dim(cfg.data, MAX_WIDTH));
            end
            if (cfg.index == REG_IMAGE_HEIGHT)
            begin
                h_eff_reg <= HW'(eff_dim(cfg.data, MAX_HEIGHT));
            end
        end
        else if (accept)
        begin
            if (in_data)
            begin
                case (byte_phase_reg)
                    PH_BLUE:
                    begin
                        held_blue_reg  <= byte_in.data_byte;
                        byte_phase_reg <= PH_GREEN;
                    end
                    PH_GREEN:
                    begin
                        held_green_reg <= byte_in.data_byte;
                        byte_phase_reg <= PH_RED;
                    end
                    default:
                    begin
                        byte_phase_reg <= PH_BLUE;
                        col_reg        <= col_reg + WW'(1);
                    end
                endcase
            end
            if (needs_push && is_last)
            begin
                rbp_reg        <= '0;
                file_row_reg   <= '0;
                col_reg        <= '0;
                byte_phase_reg <= PH_BLUE;
            end
            else if (rbp_inc >= padded)
            begin
                rbp_reg        <= '0;
                col_reg        <= '0;
                byte_phase_reg <= PH_BLUE;
                file_row_reg   <= (frow_inc >= h_eff_reg) ? '0 : frow_inc;
            end
            else
            begin
                rbp_reg <= rbp_inc;
            end
        end
    end

    a_rbp_in_row: assert property (@(posedge clk) disable iff (!rst_n)
        rbp_reg < padded)
        else $error("Byte position ran past the padded row.");

    a_row_in_image: assert property (@(posedge clk) disable iff (!rst_n)
        file_row_reg < h_eff_reg)
        else $error("File row ran past the image height.");

    a_last_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        (push && is_last) |=> (rbp_reg == '0 && file_row_reg == '0 && col_reg == '0))
        else $error("Counters did not return to the start after the last pixel.");

endmodule

FILE: rtl/bpq_fifo.sv
// Short job queue between the front end and the back end.
// Two-entry register queue with full and empty flags.
// Depends on bpq_pkg.
module bpq_fifo #(
    parameter int unsigned DATA_W = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  logic [DATA_W-1:0] wdata,
    output logic              full,
    input  logic              pop,
    output logic [DATA_W-1:0] rdata,
    output logic              empty
);
    import bpq_pkg::*;

    localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
    localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [DATA_W-1:0] mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;

    assign full  = count_reg == CNT_W'(QUEUE_DEPTH);
    assign empty = count_reg == '0;
    assign rdata = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                      : wr_ptr_reg + PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                      : rd_ptr_reg + PTR_W'(1);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full))
        else $error("Request pushed into a full queue.");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && empty))
        else $error("Request popped from an empty queue.");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("Queue count exceeds its depth.");

endmodule

FILE: rtl/bpq_back.sv
// Back end: classifies each queued pixel to the nearest palette color.
// Runs an iterative integer square root per palette entry and forms the pixel index.
// Depends on bpq_pkg and bpq_if.
module bpq_back #(
    parameter int unsigned MAX_WIDTH  = bpq_pkg::MAX_WIDTH_DEFAULT,
    parameter int unsigned MAX_HEIGHT = bpq_pkg::MAX_HEIGHT_DEFAULT,
    localparam int unsigned WW    = $clog2(MAX_WIDTH + 1),
    localparam int unsigned HW    = $clog2(MAX_HEIGHT + 1),
    localparam int unsigned JOB_W = 3 * bpq_pkg::BYTE_W + HW + WW + 1
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             empty,
    input  logic [JOB_W-1:0] job,
    output logic             pop,
    input  logic [WW-1:0]    width_eff,
    bpq_pixel_if.source      pixel_out
);
    import bpq_pkg::*;

    localparam int unsigned PW  = WW + HW;
    localparam int unsigned ENT_W = $clog2(PALETTE_SIZE);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQUARE,
        ST_SUM,
        ST_ROOT,
        ST_CMP,
        ST_INDEX,
        ST_DONE
    } state_t;

    state_t             state_reg;
    logic [BYTE_W-1:0]  red_reg;
    logic [BYTE_W-1:0]  green_reg;
    logic [BYTE_W-1:0]  blue_reg;
    logic [HW-1:0]      trow_reg;
    logic [WW-1:0]      col_reg;
    logic               last_reg;
    logic [ENT_W-1:0]   entry_reg;
    logic [SQ_W-1:0]    sq_r_reg;
    logic [SQ_W-1:0]    sq_g_reg;
    logic [SQ_W-1:0]    sq_b_reg;
    logic [SUM_W-1:0]   rem_reg;
    logic [RAD_W-1:0]   root_reg;
    logic [RAD_W-1:0]   bit_reg;
    logic [ROOT_W-1:0]  best_d_reg;
    logic [CODE_W-1:0]  best_code_reg;
    logic [PW-1:0]      prod_reg;
    logic               out_valid_reg;
    logic [INDEX_W-1:0] pixel_index_reg;
    logic [CODE_W-1:0]  color_code_reg;
    logic               last_pixel_reg;

    logic [BYTE_W-1:0]     job_red;
    logic [BYTE_W-1:0]     job_green;
    logic [BYTE_W-1:0]     job_blue;
    logic [HW-1:0]         job_trow;
    logic [WW-1:0]         job_col;
    logic                  job_last;
    rgb_t                  pal;
    logic [BYTE_W-1:0]     d_r;
    logic [BYTE_W-1:0]     d_g;
    logic [BYTE_W-1:0]     d_b;
    logic [RAD_W-1:0]      trial;
    logic                  take;
    logic [PW-1:0]         idx_sum;
    logic [INDEX_W+PW-1:0] idx_ext;

    assign {job_red, job_green, job_blue, job_trow, job_col, job_last} = job;

    assign pal     = PALETTE[entry_reg];
    assign d_r     = abs_diff(red_reg, pal.red);
    assign d_g     = abs_diff(green_reg, pal.green);
    assign d_b     = abs_diff(blue_reg, pal.blue);
    assign trial   = root_reg + bit_reg;
    assign take    = {1'b0, rem_reg} >= trial;
    assign idx_sum = prod_reg + PW'(col_reg);
    assign idx_ext = {{INDEX_W{1'b0}}, idx_sum};

    assign pop = (state_reg == ST_IDLE) && !empty;

    assign pixel_out.valid       = out_valid_reg;
    assign pixel_out.pixel_index = pixel_index_reg;
    assign pixel_out.color_code  = color_code_reg;
    assign pixel_out.last_pixel  = last_pixel_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            red_reg         <= '0;
            green_reg       <= '0;
            blue_reg        <= '0;
            trow_reg        <= '0;
            col_reg         <= '0;
            last_reg        <= 1'b0;
            entry_reg       <= '0;
            sq_r_reg        <= '0;
            sq_g_reg        <= '0;
            sq_b_reg        <= '0;
            rem_reg         <= '0;
            root_reg        <= '0;
            bit_reg         <= '0;
            best_d_reg      <= '0;
            best_code_reg   <= '0;
            prod_reg        <= '0;
            out_valid_reg   <= 1'b0;
            pixel_index_reg <= '0;
            color_code_reg  <= '0;
            last_pixel_reg  <= 1'b0;
        end
        else
        begin
            if (pixel_out.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (!empty)
                    begin
                        red_reg    <= job_red;
                        green_reg  <= job_green;
                        blue_reg   <= job_blue;
                        trow_reg   <= job_trow;
                        col_reg    <= job_col;
                        last_reg   <= job_last;
                        entry_reg  <= '0;
                        best_d_reg <= '1;
                        state_reg  <= ST_SQUARE;
                    end
                end
                ST_SQUARE:
                begin
                    sq_r_reg  <= SQ_W'(d_r) * SQ_W'(d_r);
                    sq_g_reg  <= SQ_W'(d_g) * SQ_W'(d_g);
                    sq_b_reg  <= SQ_W'(d_b) * SQ_W'(d_b);
                    state_reg <= ST_SUM;
                end
                ST_SUM:
                begin
                    rem_reg   <= SUM_W'(sq_r_reg) + SUM_W'(sq_g_reg) + SUM_W'(sq_b_reg);
                    root_reg  <= '0;
                    bit_reg   <= ROOT_BIT0;
                    state_reg <= ST_ROOT;
                end
                ST_ROOT:
                begin
                    if (take)
                    begin
                        rem_reg  <= rem_reg - trial[SUM_W-1:0];
                        root_reg <= (root_reg >> 1) + bit_reg;
                    end
                    else
                    begin
                        root_reg <= root_reg >> 1;
                    end
                    bit_reg <= bit_reg >> 2;
                    if (bit_reg == RAD_W'(1))
                    begin
                        state_reg <= ST_CMP;
                    end
                end
                ST_CMP:
                begin
                    if (root_reg[ROOT_W-1:0] < best_d_reg)
                    begin
                        best_d_reg    <= root_reg[ROOT_W-1:0];
                        best_code_reg <= CODE_W'(entry_reg);
                    end
                    if (entry_reg == ENT_W'(PALETTE_SIZE - 1))
                    begin
                        state_reg <= ST_INDEX;
                    end
                    else
                    begin
                        entry_reg <= entry_reg + ENT_W'(1);
                        state_reg <= ST_SQUARE;
                    end
                end
                ST_INDEX:
                begin
                    prod_reg  <= PW'(trow_reg) * PW'(width_eff);
                    state_reg <= ST_DONE;
                end
                ST_DONE:
                begin
                    if (!out_valid_reg || pixel_out.ready)
                    begin
                        out_valid_reg   <= 1'b1;
                        pixel_index_reg <= idx_ext[INDEX_W-1:0];
                        color_code_reg  <= best_code_reg;
                        last_pixel_reg  <= last_reg;
                        state_reg       <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    a_pop_starts: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> (state_reg == ST_SQUARE && entry_reg == '0))
        else $error("A popped request did not start at the first palette entry.");

    a_root_narrow: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CMP) |-> (root_reg[RAD_W-1:ROOT_W] == '0))
        else $error("Square root result is wider than expected.");

    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == ST_DONE
                                  && color_code_reg < CODE_W'(PALETTE_SIZE)))
        else $error("Result appeared outside the done state or with a bad code.");

endmodule

FILE: rtl/bmp_pixel_palette_quantizer_top.sv
// Top level of the BMP pixel palette quantizer.
// Connects the byte front end, the request queue and the classifying back end.
// Depends on bpq_pkg, bpq_if, bpq_front, bpq_fifo and bpq_back.
//
// Usage: software writes image_width (index 0) and image_height (index 1) on the
// cfg channel, then streams the pixel-data bytes of a 24-bit BMP on byte_in in file
// order, row padding included. Each complete pixel gives one result on pixel_out
// with its top-down index, its nearest palette color and a flag on the last pixel.
// A write to image_width or image_height restarts the byte stream at the first pixel.
// Bytes are taken one per cycle while cfg.valid is low, until the two-entry request
// queue is full and a red byte is waiting; padding bytes and blue and green bytes
// never wait on the queue. For each pixel the back end pops the request, then runs
// square, sum, nine square root steps and compare for each of the six colors, then
// the index multiply and result load. It takes a new pixel from the queue only once
// the last one is loaded into the output register. After reset the width and height
// are one and all counters are at the start. When the receiver stalls, the result is
// held in the output register, the back end waits with the next one finished, and
// the queue then backs up into byte_in.
module bmp_pixel_palette_quantizer_top #(
    parameter int unsigned MAX_WIDTH  = bpq_pkg::MAX_WIDTH_DEFAULT,
    parameter int unsigned MAX_HEIGHT = bpq_pkg::MAX_HEIGHT_DEFAULT
) (
    input  logic         clk,
    input  logic         rst_n,
    bpq_byte_if.sink     byte_in,
    bpq_cfg_if.sink      cfg,
    bpq_pixel_if.source  pixel_out
);
    import bpq_pkg::*;

    localparam int unsigned WW    = $clog2(MAX_WIDTH + 1);
    localparam int unsigned HW    = $clog2(MAX_HEIGHT + 1);
    localparam int unsigned JOB_W = 3 * BYTE_W + HW + WW + 1;

    logic             push;
    logic             pop;
    logic             full;
    logic             empty;
    logic [JOB_W-1:0] wr_job;
    logic [JOB_W-1:0] rd_job;
    logic [WW-1:0]    width_eff;

    bpq_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .byte_in   (byte_in),
        .cfg       (cfg),
        .push      (push),
        .job       (wr_job),
        .full      (full),
        .width_eff (width_eff)
    );

    bpq_fifo #(
        .DATA_W (JOB_W)
    ) u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (wr_job),
        .full  (full),
        .pop   (pop),
        .rdata (rd_job),
        .empty (empty)
    );

    bpq_back #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .empty     (empty),
        .job       (rd_job),
        .pop       (pop),
        .width_eff (width_eff),
        .pixel_out (pixel_out)
    );

endmodule
